// ===== rtl/core/pfsc_pkg.sv =====
`timescale 1ns / 1ps
package pfsc_pkg;
    localparam logic [2:0] FMT_U8  = 3'd0;
    localparam logic [2:0] FMT_S16 = 3'd1;
    localparam logic [2:0] FMT_S24 = 3'd2;
    localparam logic [2:0] FMT_S32 = 3'd3;
    localparam logic [2:0] FMT_F32 = 3'd4;
    localparam logic       ACT_DECODE = 1'b0;
    localparam logic       ACT_ENCODE = 1'b1;
    localparam int         NUM_STAGES = 3;
endpackage

// ===== rtl/core/pcm_float_sample_converter.sv =====
`timescale 1ns / 1ps
// pcm_float_sample_converter
// converts one audio sample per transaction between packed little-endian pcm
// and float32. s_axis_tuser is action (0 decode, 1 encode), s_axis_tdata is
// in_word; m_axis_tdata carries out_word. sample_format is written through
// cfg_wen/cfg_wdata; the user must write it only while no transaction is in
// flight, as the block itself does not enforce this. one item enters per
// cycle while m_axis is not stalled. the three register stages are: magnitude
// and sign extraction, leading-one search with rounding (decode) or scaling
// shift (encode), and float packing or clamped two's complement formation.
// the pipeline advances only when its last stage is empty or taken, so a stall
// on m_axis_tready holds every stage and drops s_axis_tready while a result
// waits in the last stage.
// reset clears all valid bits and loads sample_format with int16.
module pcm_float_sample_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // in_word
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // out_word
);
    logic [2:0] fmt_reg;
    logic [pfsc_pkg::NUM_STAGES-1:0] vld_reg;
    logic adv;

    // stage 1
    logic        a1_reg;
    logic [2:0]  f1_reg;
    logic [31:0] w1_reg;
    logic        s1_reg;
    logic [31:0] m1_reg;
    // stage 2
    logic        a2_reg;
    logic [2:0]  f2_reg;
    logic [31:0] w2_reg;
    logic        s2_reg;
    logic        z2_reg;
    logic [7:0]  e2_reg;
    logic [24:0] q2_reg;
    logic [31:0] r2_reg;
    logic        sat2_reg;
    // stage 3
    logic [31:0] out_reg;

    assign adv = !vld_reg[pfsc_pkg::NUM_STAGES-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[pfsc_pkg::NUM_STAGES-1];
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= pfsc_pkg::FMT_S16;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_wen)
                fmt_reg <= cfg_wdata;
            if (adv)
                vld_reg <= {vld_reg[pfsc_pkg::NUM_STAGES-2:0], s_axis_tvalid};
        end
    end

    // stage 1 logic: signed sample magnitude on decode
    logic [31:0] sv;
    logic        sneg;
    logic [31:0] mag;
    always_comb
    begin
        logic [31:0] w;
        w = s_axis_tdata;
        case (fmt_reg)
            pfsc_pkg::FMT_U8:  sv = {{24{~w[7]}}, ~w[7], w[6:0]};
            pfsc_pkg::FMT_S16: sv = {{16{w[15]}}, w[15:0]};
            pfsc_pkg::FMT_S24: sv = {{8{w[23]}}, w[23:0]};
            default:           sv = w;
        endcase
        sneg = sv[31];
        mag  = sneg ? (~sv + 32'd1) : sv;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= s_axis_tuser;
            f1_reg <= fmt_reg;
            w1_reg <= s_axis_tdata;
            s1_reg <= sneg;
            m1_reg <= mag;
        end
    end

    // stage 2 logic
    logic [4:0]  lz;
    logic        found;
    logic [31:0] nm;
    logic [24:0] q;
    logic        rb;
    logic        st;
    logic [7:0]  ebase;
    logic [7:0]  ex;
    // encode
    logic [7:0]  fe;
    logic [23:0] fm;
    logic [5:0]  nbits;
    logic [7:0]  thr;
    logic        enan;
    logic        fneg;
    logic [31:0] ti;
    logic        esat;
    logic [8:0]  sh;
    logic [55:0] ext;
    logic        frac;
    always_comb
    begin
        lz = 5'd0;
        found = 1'b0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!found && m1_reg[i])
            begin
                lz = 5'(31 - i);
                found = 1'b1;
            end
        end
        nm = m1_reg << lz;
        rb = nm[7];
        st = |nm[6:0];
        q  = {1'b0, nm[31:8]} + 25'(rb && (st || nm[8]));
        case (f1_reg)
            pfsc_pkg::FMT_U8:  ebase = 8'd127 + 8'd31 - 8'd7;
            pfsc_pkg::FMT_S16: ebase = 8'd127 + 8'd31 - 8'd15;
            pfsc_pkg::FMT_S24: ebase = 8'd127 + 8'd31 - 8'd23;
            default:           ebase = 8'd127 + 8'd31 - 8'd31;
        endcase
        ex = ebase - {3'd0, lz};

        fe = w1_reg[30:23];
        fm = {(fe != 8'd0), w1_reg[22:0]};
        fneg = w1_reg[31];
        case (f1_reg)
            pfsc_pkg::FMT_U8:  nbits = 6'd8;
            pfsc_pkg::FMT_S16: nbits = 6'd16;
            pfsc_pkg::FMT_S24: nbits = 6'd24;
            default:           nbits = 6'd32;
        endcase
        // |v| >= 2^(n-1) when unbiased exponent + (n-1) >= n-1, i.e. fe >= 127
        thr  = 8'd127;
        enan = (fe == 8'hFF) && (w1_reg[22:0] != 23'd0);
        esat = (fe >= thr);
        // value*2^(n-1) = fm * 2^(fe-127-23+n-1); result scaled by 2^24 fraction
        sh  = 9'(fe) + 9'(nbits) - 9'd1;  // shift of fm<<? relative to 2^(127+23)
        ext = 56'd0;
        if (sh >= 9'd127 + 9'd23 - 9'd24 && sh < 9'd127 + 9'd23 + 9'd32)
            ext = {32'd0, fm} << (sh - 9'd126);
        ti   = ext[55:24];
        frac = |ext[23:0] || (sh < 9'd126 && fm != 24'd0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a2_reg <= a1_reg;
            f2_reg <= f1_reg;
            w2_reg <= w1_reg;
            q2_reg <= q;
            e2_reg <= ex;
            if (a1_reg == pfsc_pkg::ACT_ENCODE)
            begin
                s2_reg   <= enan ? 1'b1 : fneg;
                sat2_reg <= enan || esat;
                r2_reg   <= ti;
                // u8 floor: negative with fraction rounds down by one more
                z2_reg   <= fneg && frac && !esat && !enan;
            end
            else
            begin
                s2_reg   <= s1_reg;
                sat2_reg <= 1'b0;
                r2_reg   <= '0;
                z2_reg   <= (m1_reg == 32'd0);
            end
        end
    end

    // stage 3 logic
    logic [31:0] res;
    always_comb
    begin
        logic [7:0]  ef;
        logic [31:0] sgn;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [7:0]  u8v;
        ef = q2_reg[24] ? e2_reg + 8'd1 : e2_reg;
        case (f2_reg)
            pfsc_pkg::FMT_S16: begin lo = 32'h0000_8000; hi = 32'h0000_7FFF; end
            pfsc_pkg::FMT_S24: begin lo = 32'h0080_0000; hi = 32'h007F_FFFF; end
            default:           begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
        endcase
        sgn = s2_reg ? (~r2_reg + 32'd1) : r2_reg;
        u8v = sgn[7:0] + 8'd128 - {7'd0, z2_reg};
        res = 32'd0;
        if (f2_reg == pfsc_pkg::FMT_F32)
            res = w2_reg;
        else if (f2_reg > pfsc_pkg::FMT_F32)
            res = 32'd0;
        else if (a2_reg == pfsc_pkg::ACT_DECODE)
        begin
            if (!z2_reg)
                res = {s2_reg, ef, q2_reg[24] ? q2_reg[23:1] : q2_reg[22:0]};
        end
        else if (f2_reg == pfsc_pkg::FMT_U8)
        begin
            if (sat2_reg)
                res = s2_reg ? 32'd0 : 32'd255;
            else
                res = {24'd0, u8v};
        end
        else
        begin
            if (sat2_reg)
                res = s2_reg ? lo : hi;
            else
                res = sgn;
            case (f2_reg)
                pfsc_pkg::FMT_S16: res = {16'd0, res[15:0]};
                pfsc_pkg::FMT_S24: res = {8'd0, res[23:0]};
                default:           res = res;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= res;
    end
endmodule

// ===== rtl/core/pfsc_checker.sv =====
`timescale 1ns / 1ps
module pfsc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready) else $error("ready low while output free");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped under stall");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid) else $error("result missing after three cycles");
endmodule

bind pcm_float_sample_converter pfsc_checker u_pfsc_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
